### src/eirq_pkg.sv
// Shared types, codes and helpers for the external interrupt pin controller.
`timescale 1ns / 1ps
package eirq_pkg;

    localparam int MaxPins = 8;
    localparam int WordW   = 32;

    // function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_SENSE  = 3'd0;
    localparam logic [2:0] REG_PRIO   = 3'd1;
    localparam logic [2:0] REG_SRC    = 3'd2;
    localparam logic [2:0] REG_MASK   = 3'd3;
    localparam logic [2:0] REG_CLEAR  = 3'd4;
    localparam logic [2:0] REG_MODE   = 3'd5;

    // configuration register indexes
    localparam logic CFG_SENSE_W = 1'b0;
    localparam logic CFG_WIDE    = 1'b1;

    // sense field widths
    localparam logic [2:0] SENSE_W_MIN = 3'd2;
    localparam logic [2:0] SENSE_W_MID = 3'd3;
    localparam logic [2:0] SENSE_W_MAX = 3'd4;

    // sense codes
    localparam logic [3:0] SENSE_FALL = 4'd0;
    localparam logic [3:0] SENSE_RISE = 4'd1;
    localparam logic [3:0] SENSE_LOW  = 4'd2;
    localparam logic [3:0] SENSE_HIGH = 4'd3;
    localparam logic [3:0] SENSE_BOTH = 4'd4;

    typedef struct packed {
        logic       tick;
        logic       level;
        logic       last;
        logic       pending;
        logic       keep;
        logic       mask;
        logic [3:0] prio;
        logic [2:0] sense_w;
        logic [1:0] code2;
        logic [2:0] code3;
        logic [3:0] code4;
    } t_lane_in;

    typedef struct packed {
        logic pending;
        logic last;
        logic irq;
    } t_lane_out;

    typedef struct packed {
        logic [WordW-1:0]   read_data;
        logic [MaxPins-1:0] irq_lines;
        logic               irq_any;
    } t_result;

    function automatic logic [MaxPins-1:0] f_reverse(input logic [MaxPins-1:0] v);
        logic [MaxPins-1:0] r;
        for (int i = 0; i < MaxPins; i++) begin
            r[i] = v[MaxPins-1-i];
        end
        return r;
    endfunction

endpackage

### src/eirq_if.sv
// Valid/ready channels for request items and result items.
`timescale 1ns / 1ps
interface eirq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  pin_levels;

    modport source(output valid, output func, output reg_index, output write_data,
                   output pin_levels, input ready);
    modport sink(input valid, input func, input reg_index, input write_data,
                 input pin_levels, output ready);
endinterface

interface eirq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [7:0]  irq_lines;
    logic        irq_any;

    modport source(output valid, output read_data, output irq_lines, output irq_any,
                   input ready);
    modport sink(input valid, input read_data, input irq_lines, input irq_any,
                 output ready);
endinterface

### src/eirq_lane.sv
// Per-pin lane: edge/level detection, pending latch and interrupt qualify.
`timescale 1ns / 1ps
module eirq_lane (
    input  eirq_pkg::t_lane_in  i_lane,
    output eirq_pkg::t_lane_out o_lane
);
    import eirq_pkg::*;

    logic [3:0] code;
    logic       fire;
    logic       pending_nx;

    always_comb begin
        case (i_lane.sense_w)
            SENSE_W_MIN: code = {2'b00, i_lane.code2};
            SENSE_W_MID: code = {1'b0, i_lane.code3};
            default:     code = i_lane.code4;
        endcase
    end

    always_comb begin
        case (code)
            SENSE_FALL: fire = i_lane.last & ~i_lane.level;
            SENSE_RISE: fire = ~i_lane.last & i_lane.level;
            SENSE_LOW:  fire = ~i_lane.level;
            SENSE_HIGH: fire = i_lane.level;
            SENSE_BOTH: fire = i_lane.last ^ i_lane.level;
            default:    fire = 1'b0;
        endcase
    end

    assign pending_nx     = (i_lane.pending & i_lane.keep) | (i_lane.tick & fire);
    assign o_lane.pending = pending_nx;
    assign o_lane.last    = i_lane.tick ? i_lane.level : i_lane.last;
    assign o_lane.irq     = pending_nx & ~i_lane.mask & (|i_lane.prio);

endmodule

### src/eirq_skid.sv
// Two-entry output buffer; the request side waits only while both entries are held.
`timescale 1ns / 1ps
module eirq_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  eirq_pkg::t_result i_data,
    output logic              o_ready,
    input  logic              i_out_ready,
    output logic              o_valid,
    output eirq_pkg::t_result o_data
);
    import eirq_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid & i_out_ready;
    assign o_ready = ~r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_main_valid && !pop) begin
            // main is held; park a new transfer in the skid slot
            if (i_push) begin
                r_skid_valid <= 1'b1;
                r_skid       <= i_data;
            end
        end else if (r_skid_valid) begin
            r_main_valid <= 1'b1;
            r_main       <= r_skid;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= i_push;
            r_main       <= i_data;
        end
    end

endmodule

### src/external_irq_pin_controller.sv
// Top level: register file, pin lanes, result merge and output buffer.
// Each result is registered in the output buffer before it appears on o_out.
// Throughput: one request per cycle; the two-entry output buffer keeps i_in.ready
// high until two results are held behind a stalled consumer.
// Reset (synchronous, i_rst_n low): sense, priority, mode, source and last levels
// clear, all pins masked, sense width 4, narrow flag registers, output buffer empty.
`timescale 1ns / 1ps
module external_irq_pin_controller #(
    parameter int NUM_PINS = eirq_pkg::MaxPins
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    eirq_in_if.sink    i_in,
    eirq_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [2:0] i_cfg_data
);
    import eirq_pkg::*;

    logic [WordW-1:0]   r_sense;
    logic [WordW-1:0]   r_prio;
    logic [WordW-1:0]   r_mode;
    logic [MaxPins-1:0] r_pending;
    logic [MaxPins-1:0] r_mask;
    logic [MaxPins-1:0] r_last;
    logic [2:0]         r_sense_w;
    logic               r_wide;

    logic [WordW-1:0]   n_sense;
    logic [WordW-1:0]   n_prio;
    logic [WordW-1:0]   n_mode;
    logic [MaxPins-1:0] n_pending;
    logic [MaxPins-1:0] n_mask;
    logic [MaxPins-1:0] n_last;

    logic               accept;
    logic               tick;
    logic               rd;
    logic               wr;
    logic [2:0]         sense_w;
    logic [MaxPins-1:0] data_pins;
    logic [MaxPins-1:0] irq;
    logic [WordW-1:0]   rdata;
    logic               buf_ready;
    t_result            result;
    t_result            out_data;

    assign accept = i_in.valid & buf_ready;
    assign i_in.ready = buf_ready;
    assign tick   = accept && (i_in.func == FUNC_TICK);
    assign rd     = accept && (i_in.func == FUNC_READ);
    assign wr     = accept && (i_in.func == FUNC_WRITE);

    always_comb begin
        if (r_sense_w < SENSE_W_MIN) begin
            sense_w = SENSE_W_MIN;
        end else if (r_sense_w > SENSE_W_MAX) begin
            sense_w = SENSE_W_MAX;
        end else begin
            sense_w = r_sense_w;
        end
    end

    // pin n sits at bit WordW-1-n (wide) or MaxPins-1-n (narrow) of the flag word
    assign data_pins = r_wide ? f_reverse(i_in.write_data[WordW-1 -: MaxPins])
                              : f_reverse(i_in.write_data[MaxPins-1:0]);

    assign n_sense = (wr && i_in.reg_index == REG_SENSE) ? i_in.write_data : r_sense;
    assign n_prio  = (wr && i_in.reg_index == REG_PRIO)  ? i_in.write_data : r_prio;
    assign n_mode  = (wr && i_in.reg_index == REG_MODE)  ? i_in.write_data : r_mode;

    always_comb begin
        n_mask = r_mask;
        if (wr && i_in.reg_index == REG_MASK) begin
            n_mask = r_mask | data_pins;
        end else if (wr && i_in.reg_index == REG_CLEAR) begin
            n_mask = r_mask & ~data_pins;
        end
    end

    for (genvar g = 0; g < MaxPins; g++) begin : g_lane
        if (g < NUM_PINS) begin : g_on
            t_lane_in  lane_in;
            t_lane_out lane_out;

            always_comb begin
                lane_in.tick    = tick;
                lane_in.level   = i_in.pin_levels[g];
                lane_in.last    = r_last[g];
                lane_in.pending = r_pending[g];
                lane_in.keep    = !(wr && i_in.reg_index == REG_SRC) || data_pins[g];
                lane_in.mask    = n_mask[g];
                lane_in.prio    = n_prio[WordW-1-4*g -: 4];
                lane_in.sense_w = sense_w;
                lane_in.code2   = r_sense[WordW-1-2*g -: 2];
                lane_in.code3   = r_sense[WordW-1-3*g -: 3];
                lane_in.code4   = r_sense[WordW-1-4*g -: 4];
            end

            eirq_lane u_lane (
                .i_lane (lane_in),
                .o_lane (lane_out)
            );

            assign n_pending[g] = lane_out.pending;
            assign n_last[g]    = lane_out.last;
            assign irq[g]       = lane_out.irq;
        end else begin : g_off
            assign n_pending[g] = 1'b0;
            assign n_last[g]    = 1'b0;
            assign irq[g]       = 1'b0;
        end
    end

    always_comb begin
        case (i_in.reg_index)
            REG_SENSE:  rdata = r_sense;
            REG_PRIO:   rdata = r_prio;
            REG_SRC:    rdata = r_wide ? {f_reverse(r_pending), {(WordW-MaxPins){1'b0}}}
                                       : {{(WordW-MaxPins){1'b0}}, f_reverse(r_pending)};
            REG_MASK:   rdata = r_wide ? {f_reverse(r_mask), {(WordW-MaxPins){1'b0}}}
                                       : {{(WordW-MaxPins){1'b0}}, f_reverse(r_mask)};
            REG_MODE:   rdata = r_mode;
            default:    rdata = '0;
        endcase
    end

    assign result.read_data = rd ? rdata : '0;
    assign result.irq_lines = irq;
    assign result.irq_any   = |irq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sense   <= '0;
            r_prio    <= '0;
            r_mode    <= '0;
            r_pending <= '0;
            r_mask    <= '1;
            r_last    <= '0;
            r_sense_w <= SENSE_W_MAX;
            r_wide    <= 1'b0;
        end else begin
            if (accept) begin
                r_sense   <= n_sense;
                r_prio    <= n_prio;
                r_mode    <= n_mode;
                r_pending <= n_pending;
                r_mask    <= n_mask;
                r_last    <= n_last;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SENSE_W) begin
                    r_sense_w <= i_cfg_data;
                end else begin
                    r_wide <= i_cfg_data[0];
                end
            end
        end
    end

    eirq_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (result),
        .o_ready     (buf_ready),
        .i_out_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_data      (out_data)
    );

    assign o_out.read_data = out_data.read_data;
    assign o_out.irq_lines = out_data.irq_lines;
    assign o_out.irq_any   = out_data.irq_any;

endmodule

### src/eirq_checker.sv
// Port-level checks for the external interrupt pin controller, bound to the top.
`timescale 1ns / 1ps
module eirq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_read_data,
    input logic [7:0]  i_irq_lines,
    input logic        i_irq_any
);

    // summary line follows the per-pin lines
    a_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_irq_any == (|i_irq_lines)))
        else $error("irq_any does not match irq_lines");

    // request side stalls only when results are backed up
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !$past(i_out_ready)))
        else $error("request side stalled without a held result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_read_data) && $stable(i_irq_lines)))
        else $error("stalled result changed");

endmodule

bind external_irq_pin_controller eirq_checker u_eirq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_read_data (o_out.read_data),
    .i_irq_lines (o_out.irq_lines),
    .i_irq_any   (o_out.irq_any)
);
